[rtl/core/ntc_temp_filter_protect_defines.svh]
// assertion macros used by the checker
`ifndef NTC_TEMP_FILTER_PROTECT_DEFINES_SVH
`define NTC_TEMP_FILTER_PROTECT_DEFINES_SVH

// same-cycle implication
`define NTF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ntf_pkg.sv]
`default_nettype none

package ntf_pkg;

    localparam int RING_DEPTH = 5;
    localparam int ADC_BITS   = 12;
    localparam int DATA_W     = 16;

    localparam int IDX_W    = $clog2(RING_DEPTH);
    localparam int SUM_W    = ADC_BITS + $clog2(RING_DEPTH);
    localparam int TRIM_DIV = RING_DEPTH - 2;

    localparam longint unsigned MEAN_RECIP_L = (64'd1 << SUM_W) / TRIM_DIV;
    localparam logic [SUM_W:0]  MEAN_RECIP   = MEAN_RECIP_L[SUM_W:0];

    localparam int SCALE_DIV = 10000;
    localparam int DIV_W     = $clog2(SCALE_DIV);
    localparam int PROD_W    = DATA_W + ADC_BITS;
    localparam int Q_W       = PROD_W - DIV_W + 1;
    localparam int HALF_W    = (PROD_W + 1) / 2;
    localparam int PP_W      = HALF_W + Q_W;
    localparam int ACC_W     = PROD_W + Q_W;

    localparam longint unsigned SCALE_RECIP_L = (64'd1 << PROD_W) / SCALE_DIV;
    localparam logic [Q_W-1:0]  SCALE_RECIP   = SCALE_RECIP_L[Q_W-1:0];

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int APB_W     = 32;

    localparam logic [DATA_W-1:0] TIMER_MAX = '1;

    localparam logic [DATA_W-1:0] RST_ADC_SCALE   = 16'd1221;
    localparam logic [DATA_W-1:0] RST_FAULT_LOW   = 16'd15;
    localparam logic [DATA_W-1:0] RST_FAULT_HIGH  = 16'd478;
    localparam logic [DATA_W-1:0] RST_SEVERE      = 16'd22;
    localparam logic [DATA_W-1:0] RST_MILD        = 16'd28;
    localparam logic [DATA_W-1:0] RST_RESTORE     = 16'd148;
    localparam logic [DATA_W-1:0] RST_SHORT_HOLD  = 16'd50;
    localparam logic [DATA_W-1:0] RST_LONG_HOLD   = 16'd1800;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ADC_SCALE,
        REG_FAULT_LOW,
        REG_FAULT_HIGH,
        REG_SEVERE,
        REG_MILD,
        REG_RESTORE,
        REG_SHORT_HOLD,
        REG_LONG_HOLD
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] adc_scale;
        logic [DATA_W-1:0] fault_low_limit;
        logic [DATA_W-1:0] fault_high_limit;
        logic [DATA_W-1:0] severe_limit;
        logic [DATA_W-1:0] mild_limit;
        logic [DATA_W-1:0] restore_limit;
        logic [DATA_W-1:0] short_hold;
        logic [DATA_W-1:0] long_hold;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic [ADC_BITS-1:0] sample;
    } smp_word_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] voltage;
    } volt_word_t;

    typedef enum logic [3:0] {
        MS_IDLE,
        MS_SCAN,
        MS_TRIM,
        MS_MDIV,
        MS_MFIX,
        MS_SCALE,
        MS_RLO,
        MS_RHI,
        MS_RSUM,
        MS_RFIX,
        MS_DONE
    } mean_state_t;

endpackage

`default_nettype wire

[rtl/core/ntc_temp_filter_protect.sv]
// thermistor sample filter with sensor-fault and overheat protection
// input side is a queue: drive adc_sample with push, a word is taken when full is low
// result side is a queue: sensor_voltage, overheat and sensor_fault are valid while
// empty is low, and the word is taken on a cycle with pop high
// a two-word input queue feeds a sequencer that scans the ring one entry a cycle,
// then trims, divides by ring depth minus two and scales with a split multiplier
// the sequencer takes a new word only when idle, so it is through with the ring scan,
// the eight arithmetic steps and the hand-off of the last result before the next word
// a stalled receiver holds its word in the result register; the sequencer then
// waits and the input queue keeps taking words until it fills
// registers sit on an apb port at byte offsets 4*i, written on the access cycle
// reset clears the ring to zeros, the timers and flags, and restores register defaults
`default_nettype none

module ntc_temp_filter_protect
    import ntf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [ADC_BITS-1:0] adc_sample,
    output logic                     empty,
    input  wire logic                pop,
    output logic [DATA_W-1:0]        sensor_voltage,
    output logic                     overheat,
    output logic                     sensor_fault,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]         prdata,
    output logic                     pready
);

    cfg_t       cfg_reg, cfg_next;
    smp_word_t  smp;
    logic       smp_take;
    volt_word_t volt;
    logic       volt_ready;
    reg_idx_t   reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_ADC_SCALE:  cfg_next.adc_scale        = pwdata[DATA_W-1:0];
                REG_FAULT_LOW:  cfg_next.fault_low_limit  = pwdata[DATA_W-1:0];
                REG_FAULT_HIGH: cfg_next.fault_high_limit = pwdata[DATA_W-1:0];
                REG_SEVERE:     cfg_next.severe_limit     = pwdata[DATA_W-1:0];
                REG_MILD:       cfg_next.mild_limit       = pwdata[DATA_W-1:0];
                REG_RESTORE:    cfg_next.restore_limit    = pwdata[DATA_W-1:0];
                REG_SHORT_HOLD: cfg_next.short_hold       = pwdata[DATA_W-1:0];
                REG_LONG_HOLD:  cfg_next.long_hold        = pwdata[DATA_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ADC_SCALE:  prdata = APB_W'(cfg_reg.adc_scale);
            REG_FAULT_LOW:  prdata = APB_W'(cfg_reg.fault_low_limit);
            REG_FAULT_HIGH: prdata = APB_W'(cfg_reg.fault_high_limit);
            REG_SEVERE:     prdata = APB_W'(cfg_reg.severe_limit);
            REG_MILD:       prdata = APB_W'(cfg_reg.mild_limit);
            REG_RESTORE:    prdata = APB_W'(cfg_reg.restore_limit);
            REG_SHORT_HOLD: prdata = APB_W'(cfg_reg.short_hold);
            REG_LONG_HOLD:  prdata = APB_W'(cfg_reg.long_hold);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_scale        <= RST_ADC_SCALE;
            cfg_reg.fault_low_limit  <= RST_FAULT_LOW;
            cfg_reg.fault_high_limit <= RST_FAULT_HIGH;
            cfg_reg.severe_limit     <= RST_SEVERE;
            cfg_reg.mild_limit       <= RST_MILD;
            cfg_reg.restore_limit    <= RST_RESTORE;
            cfg_reg.short_hold       <= RST_SHORT_HOLD;
            cfg_reg.long_hold        <= RST_LONG_HOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ntf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .adc_sample (adc_sample),
        .full       (full),
        .smp        (smp),
        .smp_take   (smp_take)
    );

    ntf_mean u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .adc_scale  (cfg_reg.adc_scale),
        .smp        (smp),
        .smp_take   (smp_take),
        .volt       (volt),
        .volt_ready (volt_ready)
    );

    ntf_prot u_prot (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .volt           (volt),
        .volt_ready     (volt_ready),
        .empty          (empty),
        .pop            (pop),
        .sensor_voltage (sensor_voltage),
        .overheat       (overheat),
        .sensor_fault   (sensor_fault)
    );

endmodule

`default_nettype wire

[rtl/core/ntf_front.sv]
`default_nettype none

module ntf_front
    import ntf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic [ADC_BITS-1:0] adc_sample,
    output logic                     full,
    output smp_word_t                smp,
    input  wire logic                smp_take
);

    logic [ADC_BITS-1:0] mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                push_ok;
    logic                pop_ok;

    assign full       = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign push_ok    = push && !full;
    assign smp.valid  = (cnt_reg != '0);
    assign smp.sample = mem_reg[rd_ptr_reg];
    assign pop_ok     = smp_take && smp.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_ok && !pop_ok)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= adc_sample;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ntf_mean.sv]
`default_nettype none

module ntf_mean
    import ntf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [DATA_W-1:0] adc_scale,
    input  wire smp_word_t         smp,
    output logic                   smp_take,
    output volt_word_t             volt,
    input  wire logic              volt_ready
);

    mean_state_t         state_reg, state_next;
    logic [ADC_BITS-1:0] ring_reg [RING_DEPTH];
    logic [ADC_BITS-1:0] ring_next [RING_DEPTH];
    logic [IDX_W-1:0]    wslot_reg, wslot_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [ADC_BITS-1:0] hi_reg, hi_next;
    logic [ADC_BITS-1:0] lo_reg, lo_next;
    logic [SUM_W-1:0]    trim_reg, trim_next;
    logic [ADC_BITS-1:0] mq_reg, mq_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [PP_W-1:0]     pp_lo_reg, pp_lo_next;
    logic [PP_W-1:0]     pp_hi_reg, pp_hi_next;
    logic [Q_W-1:0]      q_reg, q_next;

    logic [ADC_BITS-1:0] entry;
    logic [2*SUM_W:0]    mprod;
    logic [SUM_W-1:0]    mback;
    logic [SUM_W-1:0]    mrem;
    logic [ACC_W-1:0]    acc;
    logic [PROD_W-1:0]   sback;
    logic [PROD_W-1:0]   srem;

    assign entry = ring_reg[idx_reg];
    assign mprod = (2*SUM_W+1)'(trim_reg) * (2*SUM_W+1)'(MEAN_RECIP);
    assign mback = SUM_W'(mq_reg) * SUM_W'(TRIM_DIV);
    assign mrem  = trim_reg - mback;
    assign acc   = (ACC_W'(pp_hi_reg) << HALF_W) + ACC_W'(pp_lo_reg);
    assign sback = PROD_W'(q_reg) * PROD_W'(SCALE_DIV);
    assign srem  = prod_reg - sback;

    assign volt.voltage = DATA_W'(q_reg);
    assign volt.valid   = (state_reg == MS_DONE);

    always_comb
    begin
        state_next = state_reg;
        ring_next  = ring_reg;
        wslot_next = wslot_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        trim_next  = trim_reg;
        mq_next    = mq_reg;
        prod_next  = prod_reg;
        pp_lo_next = pp_lo_reg;
        pp_hi_next = pp_hi_reg;
        q_next     = q_reg;
        smp_take   = 1'b0;
        case (state_reg)
            MS_IDLE:
            begin
                smp_take = 1'b1;
                if (smp.valid)
                begin
                    ring_next[wslot_reg] = smp.sample;
                    wslot_next = (wslot_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                       : wslot_reg + IDX_W'(1);
                    idx_next   = '0;
                    state_next = MS_SCAN;
                end
            end
            MS_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    sum_next = SUM_W'(entry);
                    hi_next  = entry;
                    lo_next  = entry;
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(entry);
                    hi_next  = (entry > hi_reg) ? entry : hi_reg;
                    lo_next  = (entry < lo_reg) ? entry : lo_reg;
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(RING_DEPTH - 1))
                begin
                    state_next = MS_TRIM;
                end
            end
            MS_TRIM:
            begin
                trim_next  = sum_reg - SUM_W'(hi_reg) - SUM_W'(lo_reg);
                state_next = MS_MDIV;
            end
            MS_MDIV:
            begin
                mq_next    = mprod[SUM_W +: ADC_BITS];
                state_next = MS_MFIX;
            end
            MS_MFIX:
            begin
                if (mrem >= SUM_W'(TRIM_DIV))
                begin
                    mq_next = mq_reg + ADC_BITS'(1);
                end
                state_next = MS_SCALE;
            end
            MS_SCALE:
            begin
                prod_next  = PROD_W'(adc_scale) * PROD_W'(mq_reg);
                state_next = MS_RLO;
            end
            MS_RLO:
            begin
                pp_lo_next = PP_W'(prod_reg[HALF_W-1:0]) * PP_W'(SCALE_RECIP);
                state_next = MS_RHI;
            end
            MS_RHI:
            begin
                pp_hi_next = PP_W'(prod_reg[PROD_W-1:HALF_W]) * PP_W'(SCALE_RECIP);
                state_next = MS_RSUM;
            end
            MS_RSUM:
            begin
                q_next     = acc[PROD_W +: Q_W];
                state_next = MS_RFIX;
            end
            MS_RFIX:
            begin
                if (srem >= PROD_W'(SCALE_DIV))
                begin
                    q_next = q_reg + Q_W'(1);
                end
                state_next = MS_DONE;
            end
            MS_DONE:
            begin
                if (volt_ready)
                begin
                    state_next = MS_IDLE;
                end
            end
            default:
            begin
                state_next = MS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            wslot_reg <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            wslot_reg <= wslot_next;
            idx_reg   <= idx_next;
            ring_reg  <= ring_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        trim_reg  <= trim_next;
        mq_reg    <= mq_next;
        prod_reg  <= prod_next;
        pp_lo_reg <= pp_lo_next;
        pp_hi_reg <= pp_hi_next;
        q_reg     <= q_next;
    end

endmodule

`default_nettype wire

[rtl/core/ntf_prot.sv]
`default_nettype none

module ntf_prot
    import ntf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire volt_word_t        volt,
    output logic                   volt_ready,
    output logic                   empty,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      sensor_voltage,
    output logic                   overheat,
    output logic                   sensor_fault
);

    logic [DATA_W-1:0] ft_reg, ft_next;
    logic [DATA_W-1:0] st_reg, st_next;
    logic [DATA_W-1:0] mt_reg, mt_next;
    logic [DATA_W-1:0] rt_reg, rt_next;
    logic              oh_reg, oh_next;
    logic              ff_reg, ff_next;
    logic              res_valid_reg, res_valid_next;
    logic [DATA_W-1:0] res_volt_reg;
    logic              res_oh_reg;
    logic              res_ff_reg;
    logic              load;

    assign empty          = !res_valid_reg;
    assign volt_ready     = !res_valid_reg || pop;
    assign load           = volt.valid && volt_ready;
    assign sensor_voltage = res_volt_reg;
    assign overheat       = res_oh_reg;
    assign sensor_fault   = res_ff_reg;

    always_comb
    begin
        logic [DATA_W-1:0] v;
        logic              fault_win;
        v         = volt.voltage;
        fault_win = (v <= cfg.fault_low_limit) || (v >= cfg.fault_high_limit);
        ft_next   = ft_reg;
        st_next   = st_reg;
        mt_next   = mt_reg;
        rt_next   = rt_reg;
        oh_next   = oh_reg;
        ff_next   = ff_reg;
        if (fault_win)
        begin
            if (!ff_reg)
            begin
                if (ft_reg >= cfg.short_hold)
                begin
                    ff_next = 1'b1;
                    ft_next = '0;
                end
                else
                begin
                    ft_next = ft_reg + DATA_W'(1);
                end
            end
        end
        else
        begin
            ft_next = '0;
            ff_next = 1'b0;
            if (v <= cfg.severe_limit)
            begin
                if (!oh_reg)
                begin
                    if (st_reg >= cfg.short_hold)
                    begin
                        oh_next = 1'b1;
                        st_next = '0;
                    end
                    else
                    begin
                        st_next = st_reg + DATA_W'(1);
                    end
                end
                rt_next = '0;
            end
            else if (v <= cfg.mild_limit)
            begin
                if (!oh_reg)
                begin
                    if (mt_reg >= cfg.long_hold)
                    begin
                        oh_next = 1'b1;
                        mt_next = '0;
                    end
                    else
                    begin
                        mt_next = mt_reg + DATA_W'(1);
                    end
                end
                st_next = '0;
                rt_next = '0;
            end
            else
            begin
                if (oh_reg && (v >= cfg.restore_limit))
                begin
                    if (rt_reg >= cfg.long_hold)
                    begin
                        oh_next = 1'b0;
                    end
                    if (rt_reg != TIMER_MAX)
                    begin
                        rt_next = rt_reg + DATA_W'(1);
                    end
                end
                else
                begin
                    rt_next = '0;
                end
                mt_next = '0;
                st_next = '0;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ft_reg        <= '0;
            st_reg        <= '0;
            mt_reg        <= '0;
            rt_reg        <= '0;
            oh_reg        <= 1'b0;
            ff_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (load)
            begin
                ft_reg <= ft_next;
                st_reg <= st_next;
                mt_reg <= mt_next;
                rt_reg <= rt_next;
                oh_reg <= oh_next;
                ff_reg <= ff_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_volt_reg <= volt.voltage;
            res_oh_reg   <= oh_next;
            res_ff_reg   <= ff_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ntf_checker.sv]
`default_nettype none

`include "ntc_temp_filter_protect_defines.svh"

module ntf_checker
    import ntf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic              full,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire logic              pready,
    input  wire logic [DATA_W-1:0] sensor_voltage,
    input  wire logic              overheat,
    input  wire logic              sensor_fault
);

    localparam int MAX_OUT = FIFO_DEPTH + 2;
    localparam int OUT_W   = $clog2(MAX_OUT + 2);

    logic [OUT_W-1:0] out_reg, out_next;

    always_comb
    begin
        out_next = out_reg;
        if (push && !full)
        begin
            out_next = out_next + OUT_W'(1);
        end
        if (pop && !empty)
        begin
            out_next = out_next - OUT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
        end
    end

    `NTF_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready, "pready dropped")
    `NTF_ASSERT_NOW(a_no_orphan, clk, rst_n, !empty, out_reg != '0, "result word without input")
    `NTF_ASSERT_NOW(a_backlog_bound, clk, rst_n, 1'b1, out_reg <= OUT_W'(MAX_OUT), "too many words")
    `NTF_ASSERT_NOW(a_full_backlog, clk, rst_n, full, out_reg >= OUT_W'(FIFO_DEPTH), "full too early")
    `NTF_ASSERT_NEXT(a_result_hold, clk, rst_n, !empty && !pop, !empty && $stable(sensor_voltage) && $stable(overheat) && $stable(sensor_fault), "result word changed while stalled")

endmodule

bind ntc_temp_filter_protect ntf_checker u_ntf_checker (.*);

`default_nettype wire
